// ===== rtl/srtp_pkg.sv =====
// ----------------------------------------------------------------------------
// srtp_pkg
// Shared types and codes of the sample RAM transfer port.
// ----------------------------------------------------------------------------
`default_nettype none

package srtp_pkg;

  localparam int FIFO_WORDS_DEF = 8;
  localparam int RAM_BYTES_DEF  = 65536;

  localparam logic [2:0] OP_SET_ADDR   = 3'd0;
  localparam logic [2:0] OP_SET_CTRL   = 3'd1;
  localparam logic [2:0] OP_CPU_WRITE  = 3'd2;
  localparam logic [2:0] OP_CPU_READ   = 3'd3;
  localparam logic [2:0] OP_DMA_WRITE  = 3'd4;
  localparam logic [2:0] OP_DMA_READ   = 3'd5;
  localparam logic [2:0] OP_SERVICE    = 3'd6;

  localparam logic [1:0] MODE_STOP      = 2'd0;
  localparam logic [1:0] MODE_MANUAL    = 2'd1;
  localparam logic [1:0] MODE_DMA_READ  = 2'd2;
  localparam logic [1:0] MODE_DMA_WRITE = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        dma_request;
    logic        dma_read_request;
    logic        dma_write_request;
    logic        transfer_busy;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ===== rtl/srtp_ram.sv =====
// ----------------------------------------------------------------------------
// srtp_ram
// Single-port synchronous sample RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_ram #(
  parameter int WORDS = srtp_pkg::RAM_BYTES_DEF / 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(WORDS)-1:0] addr,
  input  wire logic [31:0]              wdata,
  output logic      [31:0]              rdata
);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/srtp_fifo.sv =====
// ----------------------------------------------------------------------------
// srtp_fifo
// Transfer FIFO: register store with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_fifo #(
  parameter int DEPTH = srtp_pkg::FIFO_WORDS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire srtp_pkg::fifo_ctl_t        ctl,
  input  wire logic [31:0]                push_data,
  output logic      [31:0]                head,
  output logic      [$clog2(DEPTH+1)-1:0] count,
  output srtp_pkg::fifo_sts_t             sts
);
  import srtp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [31:0]      store [DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign sts.full  = (count_r == CNT_W'(DEPTH));
  assign sts.empty = (count_r == '0);
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;
  assign head      = store[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (ctl.clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      count_nxt  = '0;
    end else begin
      if (do_push) begin
        wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_nxt = count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !ctl.clear) begin
      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sample_ram_transfer_port_core.sv =====
// ----------------------------------------------------------------------------
// sample_ram_transfer_port_core
// Transfer port into a sample RAM: address, data latch, mode, FIFO and batch.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  in       | in_valid/in_stall  | in_data   (opcode, data_word)
//  out      | out_valid/out_stall| out_data  (read_data, status)
//
//  register and FIFO requests pass from accept through ST_EMIT into the
//  output register (through ST_SCHED first when they touch batch scheduling);
//  a batch service moves one word per cycle through the single RAM port.
//  one request at a time; in_stall is high from accept until the result is
//  loaded into the output register, which may wait on out_stall meanwhile.
//  synchronous reset clears control state; RAM and FIFO contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_ram_transfer_port_core #(
  parameter int FIFO_WORDS = srtp_pkg::FIFO_WORDS_DEF,
  parameter int RAM_BYTES  = srtp_pkg::RAM_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire srtp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output srtp_pkg::out_item_t      out_data
);
  import srtp_pkg::*;

  localparam int RAM_WORDS = RAM_BYTES / 4;
  localparam int ADDR_W    = $clog2(RAM_BYTES);
  localparam int IDX_W     = ADDR_W - 2;
  localparam int CNT_W     = $clog2(FIFO_WORDS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SVC_RD = 5'b00010,
    ST_SVC_WR = 5'b00100,
    ST_SCHED  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [31:0]      latch_r, latch_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic             ram_we;
  logic             ram_re;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;
  fifo_ctl_t        fifo_ctl;
  fifo_sts_t        fifo_sts;
  logic [31:0]      fifo_push_data;
  logic [31:0]      fifo_head;
  logic [CNT_W-1:0] fifo_count;
  logic             accept;
  logic             out_free;

  srtp_ram #(
    .WORDS (RAM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  srtp_fifo #(
    .DEPTH (FIFO_WORDS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .push_data (fifo_push_data),
    .head      (fifo_head),
    .count     (fifo_count),
    .sts       (fifo_sts)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    latch_nxt      = latch_r;
    mode_nxt       = mode_r;
    pending_nxt    = pending_r;
    remain_nxt     = remain_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_wdata      = in_data.data_word;
    fifo_ctl       = '0;
    fifo_push_data = in_data.data_word;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EMIT;
          unique case (in_data.opcode)
            OP_SET_ADDR: begin
              addr_nxt = in_data.data_word[ADDR_W-1:2];
            end
            OP_SET_CTRL: begin
              if (in_data.data_word[1:0] != mode_r) begin
                pending_nxt    = '0;
                fifo_ctl.clear = 1'b1;
                mode_nxt       = in_data.data_word[1:0];
              end
              state_nxt = ST_SCHED;
            end
            OP_CPU_WRITE: begin
              latch_nxt = in_data.data_word;
              if (mode_r == MODE_MANUAL) begin
                ram_we   = 1'b1;
                addr_nxt = addr_r + 1'b1;
              end
            end
            OP_DMA_WRITE: begin
              latch_nxt     = in_data.data_word;
              fifo_ctl.push = 1'b1;
              state_nxt     = ST_SCHED;
            end
            OP_DMA_READ: begin
              if (!fifo_sts.empty) begin
                latch_nxt    = fifo_head;
                fifo_ctl.pop = 1'b1;
                state_nxt    = ST_SCHED;
              end
            end
            OP_SERVICE: begin
              remain_nxt  = pending_r;
              pending_nxt = '0;
              state_nxt   = (mode_r == MODE_DMA_READ) ? ST_SVC_RD : ST_SVC_WR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SVC_RD: begin
        // read issued last cycle lands now; a full FIFO drops the word
        if (rd_pend_r) begin
          fifo_ctl.push  = 1'b1;
          fifo_push_data = ram_rdata;
        end
        if (remain_r != '0) begin
          ram_re      = 1'b1;
          addr_nxt    = addr_r + 1'b1;
          remain_nxt  = remain_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = ST_SCHED;
        end
      end
      ST_SVC_WR: begin
        if (remain_r != '0 && !fifo_sts.empty) begin
          ram_we       = 1'b1;
          ram_wdata    = fifo_head;
          fifo_ctl.pop = 1'b1;
          addr_nxt     = addr_r + 1'b1;
          remain_nxt   = remain_r - 1'b1;
        end else begin
          state_nxt = ST_SCHED;
        end
      end
      ST_SCHED: begin
        if (pending_r == '0) begin
          if (mode_r == MODE_DMA_WRITE) begin
            pending_nxt = fifo_count;
          end else if (mode_r == MODE_DMA_READ) begin
            pending_nxt = CNT_W'(FIFO_WORDS) - fifo_count;
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      latch_r     <= '0;
      mode_r      <= MODE_STOP;
      pending_r   <= '0;
      remain_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      latch_r     <= latch_nxt;
      mode_r      <= mode_nxt;
      pending_r   <= pending_nxt;
      remain_r    <= remain_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r.read_data         <= latch_r;
      out_data_r.dma_read_request  <= (mode_r == MODE_DMA_READ) && fifo_sts.full;
      out_data_r.dma_write_request <= (mode_r == MODE_DMA_WRITE) && fifo_sts.empty;
      out_data_r.dma_request       <= ((mode_r == MODE_DMA_READ) && fifo_sts.full)
                                   || ((mode_r == MODE_DMA_WRITE) && fifo_sts.empty);
      out_data_r.transfer_busy     <= (pending_r != '0);
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_sample_ram_transfer_port_core.sv =====
// ----------------------------------------------------------------------------
// tb_sample_ram_transfer_port_core
// Self-checking bench for the sample RAM transfer port. A short table of
// directed requests covers reset state, address masking and wrap, mode
// changes and the FIFO corner cases. Random request sequences follow: manual
// fills, DMA write bursts, DMA read bursts and noise. A cycle-free predictor
// of the port gives every untyped result, and both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sample_ram_transfer_port_core;
  timeunit 1ns;
  timeprecision 1ps;

  import srtp_pkg::*;

  localparam int FIFO_DEPTH     = FIFO_WORDS_DEF;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int ADDR_W         = $clog2(RAM_BYTES_DEF);
  localparam int RAM_WORDS      = RAM_BYTES_DEF / 4;
  localparam logic [2:0] OP_NONE = 3'd7;

  localparam int FILL_BASE_WORD = RAM_WORDS - 32;
  localparam int FILL_WORDS     = 96;
  localparam int RANDOM_ITEMS   = 950;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  localparam out_item_t PREDICT = '0;
  localparam int DIRECTED_ROWS  = 29;

  // typed rows carry a result that follows directly from reset or extremes
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_CPU_READ,  32'h0000_0000}, 1, '{32'h0000_0000, 0, 0, 0, 0}},
    '{'{OP_NONE,      32'hFFFF_FFFF}, 1, '{32'h0000_0000, 0, 0, 0, 0}},
    '{'{OP_SET_ADDR,  32'hFFFF_FFFF}, 1, '{32'h0000_0000, 0, 0, 0, 0}},
    '{'{OP_CPU_WRITE, 32'hCAFE_F00D}, 1, '{32'hCAFE_F00D, 0, 0, 0, 0}},
    '{'{OP_SET_CTRL,  32'hFFFF_FFFD}, 1, '{32'hCAFE_F00D, 0, 0, 0, 0}},
    '{'{OP_SET_CTRL,  32'h0000_0001}, 1, '{32'hCAFE_F00D, 0, 0, 0, 0}},
    '{'{OP_CPU_WRITE, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 0, 0, 0, 0}},
    '{'{OP_CPU_WRITE, 32'h0000_0000}, 1, '{32'h0000_0000, 0, 0, 0, 0}},
    '{'{OP_CPU_WRITE, 32'h8000_0000}, 0, PREDICT},
    '{'{OP_CPU_WRITE, 32'h7FFF_FFFF}, 0, PREDICT},
    '{'{OP_CPU_WRITE, 32'h5555_5555}, 0, PREDICT},
    '{'{OP_CPU_WRITE, 32'hAAAA_AAAA}, 0, PREDICT},
    '{'{OP_CPU_WRITE, 32'h0F0F_0F0F}, 0, PREDICT},
    '{'{OP_CPU_WRITE, 32'h1234_5678}, 0, PREDICT},
    '{'{OP_SET_ADDR,  32'h7FFF_FFFE}, 0, PREDICT},
    '{'{OP_SET_CTRL,  32'h0000_0002}, 0, PREDICT},
    '{'{OP_DMA_WRITE, 32'h0000_0001}, 0, PREDICT},
    '{'{OP_SERVICE,   32'h0000_0000}, 0, PREDICT},
    '{'{OP_DMA_READ,  32'h0000_0000}, 0, PREDICT},
    '{'{OP_DMA_READ,  32'h0000_0000}, 0, PREDICT},
    '{'{OP_SET_CTRL,  32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1, 0, 1, 0}},
    '{'{OP_DMA_READ,  32'h0000_0000}, 1, '{32'hFFFF_FFFF, 1, 0, 1, 0}},
    '{'{OP_DMA_WRITE, 32'h0BAD_0001}, 0, PREDICT},
    '{'{OP_DMA_WRITE, 32'h0BAD_0002}, 0, PREDICT},
    '{'{OP_DMA_READ,  32'h0000_0000}, 0, PREDICT},
    '{'{OP_DMA_READ,  32'h0000_0000}, 0, PREDICT},
    '{'{OP_SERVICE,   32'h0000_0000}, 0, PREDICT},
    '{'{OP_SERVICE,   32'h0000_0000}, 0, PREDICT},
    '{'{OP_SET_CTRL,  32'h7FFF_FFFC}, 0, PREDICT}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sample_ram_transfer_port_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---- predictor state ----
  logic [31:0]       ram_mirror  [RAM_WORDS];
  bit                ram_written [RAM_WORDS];
  logic [31:0]       fifo_mirror [FIFO_DEPTH];
  logic [PTR_W-1:0]  fifo_head = '0;
  logic [PTR_W-1:0]  fifo_tail = '0;
  logic [PTR_W:0]    fifo_fill = '0;
  logic [ADDR_W-1:0] addr_reg = '0;
  logic [31:0]       latch_reg = '0;
  logic [1:0]        mode_reg = MODE_STOP;
  logic [PTR_W:0]    batch_left = '0;

  out_item_t port_results_due [$];
  out_item_t result_seen;
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        random_items = 0;
  int        send_calm = 0;
  int        stall_calm = 0;

  function automatic void store_word(logic [31:0] w);
    ram_mirror[addr_reg[ADDR_W-1:2]]  = w;
    ram_written[addr_reg[ADDR_W-1:2]] = 1'b1;
    addr_reg = addr_reg + 3'd4;
  endfunction

  function automatic void fifo_put(logic [31:0] w);
    if (fifo_fill < FIFO_DEPTH) begin
      fifo_mirror[fifo_tail] = w;
      fifo_tail = (fifo_tail == FIFO_DEPTH - 1) ? '0 : fifo_tail + 1'b1;
      fifo_fill = fifo_fill + 1'b1;
    end
  endfunction

  function automatic logic [31:0] fifo_take();
    logic [31:0] w;
    w = fifo_mirror[fifo_head];
    fifo_head = (fifo_head == FIFO_DEPTH - 1) ? '0 : fifo_head + 1'b1;
    fifo_fill = fifo_fill - 1'b1;
    return w;
  endfunction

  function automatic void plan_batch();
    if (batch_left == 0) begin
      if (mode_reg == MODE_DMA_WRITE) batch_left = fifo_fill;
      else if (mode_reg == MODE_DMA_READ) batch_left = (PTR_W+1)'(FIFO_DEPTH - fifo_fill);
    end
  endfunction

  function automatic void run_batch();
    logic [PTR_W:0] n;
    n = batch_left;
    batch_left = '0;
    for (int i = 0; i < n; i++) begin
      if (mode_reg == MODE_DMA_READ) begin
        // a full fifo drops the word but the address still moves on
        fifo_put(ram_mirror[addr_reg[ADDR_W-1:2]]);
        addr_reg = addr_reg + 3'd4;
      end else begin
        if (fifo_fill == 0) break;
        store_word(fifo_take());
      end
    end
    plan_batch();
  endfunction

  function automatic out_item_t predict_port_result(in_item_t req);
    out_item_t res;
    logic [31:0] w;
    w = req.data_word;
    case (req.opcode)
      OP_SET_ADDR: addr_reg = {w[ADDR_W-1:2], 2'b00};
      OP_SET_CTRL: begin
        if (w[1:0] != mode_reg) begin
          batch_left = '0;
          fifo_head  = '0;
          fifo_tail  = '0;
          fifo_fill  = '0;
          mode_reg   = w[1:0];
        end
        plan_batch();
      end
      OP_CPU_WRITE: begin
        latch_reg = w;
        if (mode_reg == MODE_MANUAL) store_word(w);
      end
      OP_DMA_WRITE: begin
        latch_reg = w;
        fifo_put(w);
        plan_batch();
      end
      OP_DMA_READ: begin
        if (fifo_fill != 0) begin
          latch_reg = fifo_take();
          plan_batch();
        end
      end
      OP_SERVICE: run_batch();
      default: ;  // cpu read and the unused code leave everything alone
    endcase
    res.read_data         = latch_reg;
    res.dma_read_request  = (mode_reg == MODE_DMA_READ) && (fifo_fill == FIFO_DEPTH);
    res.dma_write_request = (mode_reg == MODE_DMA_WRITE) && (fifo_fill == 0);
    res.dma_request       = res.dma_read_request | res.dma_write_request;
    res.transfer_busy     = (batch_left != 0);
    return res;
  endfunction

  // true when every word the pending batch will read from ram holds data
  function automatic bit batch_reads_written();
    logic [ADDR_W-3:0] word;
    word = addr_reg[ADDR_W-1:2];
    for (int i = 0; i < batch_left; i++) begin
      if (!ram_written[word]) return 1'b0;
      word = word + 1'b1;
    end
    return 1'b1;
  endfunction

  // address inside the region filled at the start of the random part
  function automatic logic [31:0] safe_address();
    logic [ADDR_W-3:0] word;
    logic [31:0] w;
    word = (ADDR_W-2)'(FILL_BASE_WORD + $urandom_range(0, FILL_WORDS - FIFO_DEPTH));
    w = $urandom();
    w[ADDR_W-1:2] = word;
    return w;
  endfunction

  function automatic logic [31:0] any_address();
    if ($urandom_range(0, 1) == 0) return safe_address();
    return $urandom();
  endfunction

  function automatic logic [31:0] ctrl_word(logic [1:0] mode);
    logic [31:0] w;
    w = $urandom();
    w[1:0] = mode;
    return w;
  endfunction

  function automatic int send_gap();
    int r;
    if (send_calm != 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_calm = 40;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_request(in_item_t req, logic typed, out_item_t want, bit drain);
    int gap;
    out_item_t res;
    gap = send_gap();
    if (gap != 0 || drain) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (drain && port_results_due.size() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_port_result(req);
    port_results_due.push_back(typed ? want : res);
  endtask

  task automatic issue(logic [2:0] op, logic [31:0] data, bit drain);
    in_item_t req;
    // never let a dma read batch touch ram that was never written
    if (op == OP_SERVICE && mode_reg == MODE_DMA_READ && batch_left != 0 &&
        !batch_reads_written()) begin
      op   = OP_SET_ADDR;
      data = safe_address();
    end
    req.opcode    = op;
    req.data_word = data;
    send_request(req, 1'b0, PREDICT, drain);
    if (op != OP_NONE) random_items++;
  endtask

  initial begin : stimulus
    int pick;
    int len;
    int r;
    bit drain;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].want, 1'b0);

    // fill a window across the top of ram and the wrap to zero
    issue(OP_SET_CTRL, ctrl_word(MODE_MANUAL), 1'b1);
    issue(OP_SET_ADDR, {16'($urandom_range(0, 65535)), 16'(FILL_BASE_WORD * 4)}, 1'b0);
    repeat (FILL_WORDS) issue(OP_CPU_WRITE, $urandom(), 1'b0);

    while (random_items < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 99) < 8);
      if (pick < 25) begin
        issue(OP_SET_CTRL, ctrl_word(MODE_MANUAL), drain);
        issue(OP_SET_ADDR, any_address(), 1'b0);
        len = $urandom_range(1, 24);
        repeat (len)
          issue(($urandom_range(0, 9) == 0) ? OP_CPU_READ : OP_CPU_WRITE, $urandom(), 1'b0);
      end else if (pick < 55) begin
        issue(OP_SET_CTRL, ctrl_word(MODE_DMA_WRITE), drain);
        issue(OP_SET_ADDR, any_address(), 1'b0);
        len = $urandom_range(4, 30);
        repeat (len) begin
          r = $urandom_range(0, 9);
          issue((r < 5) ? OP_DMA_WRITE : (r < 8) ? OP_SERVICE :
                (r < 9) ? OP_DMA_READ : OP_CPU_READ, $urandom(), 1'b0);
        end
      end else if (pick < 85) begin
        issue(OP_SET_ADDR, safe_address(), drain);
        issue(OP_SET_CTRL, ctrl_word(MODE_DMA_READ), 1'b0);
        len = $urandom_range(4, 30);
        repeat (len) begin
          r = $urandom_range(0, 19);
          if (r < 8) issue(OP_SERVICE, $urandom(), 1'b0);
          else if (r < 16) issue(OP_DMA_READ, $urandom(), 1'b0);
          else if (r < 18) issue(OP_DMA_WRITE, $urandom(), 1'b0);
          else if (r < 19) issue(OP_SET_ADDR, safe_address(), 1'b0);
          else issue(OP_CPU_WRITE, $urandom(), 1'b0);
        end
      end else begin
        len = $urandom_range(3, 12);
        repeat (len) issue(3'($urandom_range(0, 7)), $urandom(), drain);
      end
    end

    in_valid <= 1'b0;
    while (port_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver side: short stalls mostly, a few long ones, some quiet stretches
  initial begin : result_stall
    int n;
    int r;
    forever begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if (stall_calm == 0 && $urandom_range(0, 99) < 3) stall_calm = 1;
      if (stall_calm != 0) begin
        stall_calm = 0;
        repeat (100) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      n = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) :
          (r < 97) ? $urandom_range(4, 15) : $urandom_range(30, 60);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (port_results_due.size() == 0) begin
        report_mismatch("result with no request outstanding", out_data.read_data, '0);
      end else begin
        result_seen = port_results_due.pop_front();
        check_field("read_data", out_data.read_data, result_seen.read_data);
        check_field("dma_request", 32'(out_data.dma_request),
                    32'(result_seen.dma_request));
        check_field("dma_read_request", 32'(out_data.dma_read_request),
                    32'(result_seen.dma_read_request));
        check_field("dma_write_request", 32'(out_data.dma_write_request),
                    32'(result_seen.dma_write_request));
        check_field("transfer_busy", 32'(out_data.transfer_busy),
                    32'(result_seen.transfer_busy));
      end
    end
  end

  // cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== sample_ram_transfer_port_core.f =====
rtl/srtp_pkg.sv
rtl/srtp_ram.sv
rtl/srtp_fifo.sv
rtl/sample_ram_transfer_port_core.sv
test/tb_sample_ram_transfer_port_core.sv
